// ----- rtl/core/link_control_word_parser_assert.svh -----
// Assertion macros for the link control word parser.
`ifndef LINK_CONTROL_WORD_PARSER_ASSERT_SVH
`define LINK_CONTROL_WORD_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCWP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define LCWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");
`else
`define LCWP_ASSERT(label, clk, rst_n, prop)
`define LCWP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/lcwp_pkg.sv -----
// Package with types, constants and helpers of the link control word parser.
`timescale 1ns / 1ps
package lcwp_pkg;
  localparam int AliasMaxChars = 21;
  localparam int BlockChars    = 7;
  localparam int StoreDepth    = 22;

  localparam logic [5:0] OpGroupVoice = 6'h00;
  localparam logic [5:0] OpUnitToUnit = 6'h03;
  localparam logic [5:0] OpRegroup    = 6'h0A;
  localparam logic [5:0] OpAliasHdr   = 6'h15;
  localparam logic [5:0] OpAliasBlk1  = 6'h16;
  localparam logic [5:0] OpAliasBlk2  = 6'h17;
  localparam logic [5:0] OpAliasBlk3  = 6'h18;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindGroup = 2'd1;
  localparam logic [1:0] KindUnit  = 2'd2;
  localparam logic [1:0] KindRegrp = 2'd3;

  typedef enum logic [2:0] {
    CmdNone, CmdClear, CmdVoice, CmdUnit, CmdHeader, CmdBlock
  } cmd_e;

  // Classified word handed from the front end to the executor.
  typedef struct packed {
    cmd_e        cmd;
    logic        valid_word;  // word passed FEC (timeout check applies)
    logic        regroup;
    logic [1:0]  blk;         // block number 1..3
    logic [55:0] info;
    logic [61:0] now;
  } op_t;

  localparam int OpW = $bits(op_t);

  // Input beat data: lco, mfid, info_bytes, fec_ok, now_us (req_type travels in tuser).
  localparam int InW  = 8 + 8 + 56 + 1 + 62;
  localparam int InTW = ((InW + 7) / 8) * 8;
  // Output beat fields.
  localparam int OutW  = 1 + 2 + 8 + 16 + 24 + 24 + 16 + 1 + 5 + 3 * 56;
  localparam int OutTW = ((OutW + 7) / 8) * 8;

  function automatic logic [7:0] info_byte(logic [55:0] info, int k);
    return info[8 * (6 - k) +: 8];
  endfunction
endpackage

// ----- rtl/core/lcwp_front.sv -----
// Front end: accepts input beats, classifies them and pushes commands.
`timescale 1ns / 1ps
module lcwp_front import lcwp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [InTW-1:0] s_data_i,
  input  logic            s_user_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output op_t             q_op_o
);
  logic        req_type, fec_ok;
  logic [7:0]  lco, mfid;
  logic [55:0] info;
  logic [61:0] now;
  logic [5:0]  op;
  logic        std;
  op_t         op_d, op_q;
  logic        vld_q;

  assign req_type = s_user_i;
  assign lco      = s_data_i[7:0];
  assign mfid     = s_data_i[15:8];
  assign info     = s_data_i[71:16];
  assign fec_ok   = s_data_i[72];
  assign now      = s_data_i[134:73];
  assign op       = lco[5:0];
  assign std      = (mfid == 8'h00) || (mfid == 8'h01);

  always_comb begin
    op_d            = '0;
    op_d.info       = info;
    op_d.now        = now;
    op_d.cmd        = CmdNone;
    op_d.valid_word = 1'b0;
    op_d.regroup    = (op == OpRegroup);
    op_d.blk        = op[1:0] - 2'd1;
    if (req_type) begin
      op_d.cmd = CmdClear;
    end else if (fec_ok) begin
      op_d.valid_word = 1'b1;
      if (std) begin
        case (op)
          OpGroupVoice, OpRegroup:               op_d.cmd = CmdVoice;
          OpUnitToUnit:                          op_d.cmd = CmdUnit;
          OpAliasHdr:                            op_d.cmd = CmdHeader;
          OpAliasBlk1, OpAliasBlk2, OpAliasBlk3: op_d.cmd = CmdBlock;
          default:                               op_d.cmd = CmdNone;
        endcase
      end
      if (op == OpAliasBlk3) op_d.blk = 2'd3;
      else if (op == OpAliasBlk1) op_d.blk = 2'd1;
      else op_d.blk = 2'd2;
    end
  end

  // One-entry queue between front and back.
  assign s_ready_o = !vld_q || q_ready_i;
  assign q_valid_o = vld_q;
  assign q_op_o    = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_ready_o) begin
      vld_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      op_q <= op_d;
    end
  end
endmodule

// ----- rtl/core/lcwp_back.sv -----
// Back end: executes commands on the call record and alias store.
`timescale 1ns / 1ps
module lcwp_back import lcwp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  op_t              q_op_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [OutTW-1:0] m_data_o
);
  logic [31:0] tmo_q;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  svc_q, svc_d;
  logic [15:0] grp_q, grp_d, sgrp_q, sgrp_d, ltg_q, ltg_d;
  logic [23:0] src_q, src_d, tgt_q, tgt_d, lsrc_q, lsrc_d;
  logic [4:0]  exp_q, exp_d, fill_q, fill_d;
  logic [3:0]  seen_q, seen_d;
  logic        done_q, done_d;
  logic [61:0] start_q, start_d;
  logic [7:0]  store_q [StoreDepth];
  logic [7:0]  store_d [StoreDepth];
  logic        handled;
  logic        fire;
  logic        out_vld_q;
  logic [OutTW-1:0] out_q;

  logic [15:0] tg;
  logic [23:0] src;
  logic [62:0] diff;
  logic [4:0]  offset, len, take, written;
  logic        stop;
  logic [3:0]  bit_m;
  logic [7:0]  c;
  logic [7:0]  hdr_len;

  assign q_ready_o = !out_vld_q || m_ready_i;
  assign fire      = q_valid_i && q_ready_o;
  assign tg        = {info_byte(q_op_i.info, 2), info_byte(q_op_i.info, 3)};
  assign src       = q_op_i.info[23:0];
  assign diff      = {1'b0, q_op_i.now} - {1'b0, start_q};
  assign hdr_len   = info_byte(q_op_i.info, 1);

  always_comb begin
    kind_d = kind_q; svc_d = svc_q; grp_d = grp_q; sgrp_d = sgrp_q;
    src_d = src_q; tgt_d = tgt_q; ltg_d = ltg_q; lsrc_d = lsrc_q;
    exp_d = exp_q; seen_d = seen_q; fill_d = fill_q; done_d = done_q;
    start_d = start_q;
    for (int i = 0; i < StoreDepth; i++) store_d[i] = store_q[i];
    handled = 1'b0;
    offset = '0; len = '0; take = '0; written = '0; stop = 1'b0;
    bit_m = '0; c = '0;
    if (q_op_i.cmd == CmdClear) begin
      kind_d = KindNone; svc_d = '0; grp_d = '0; src_d = '0; tgt_d = '0;
      sgrp_d = '0;
      exp_d = '0; seen_d = '0; fill_d = '0; done_d = 1'b0; start_d = '0;
      store_d[0] = '0;
    end else if (q_op_i.valid_word) begin
      if (exp_q != '0 && !done_q && !diff[62] && diff[61:0] > {30'd0, tmo_q}) begin
        exp_d = '0; seen_d = '0; fill_d = '0; done_d = 1'b0; start_d = '0;
        store_d[0] = '0;
      end
      case (q_op_i.cmd)
        CmdVoice: begin
          handled = 1'b1;
          if ((ltg_q != '0 && tg != '0 && ltg_q != tg) ||
              (lsrc_q != '0 && src != '0 && lsrc_q != src)) begin
            exp_d = '0; seen_d = '0; fill_d = '0; done_d = 1'b0; start_d = '0;
            store_d[0] = '0;
          end
          svc_d  = info_byte(q_op_i.info, 0);
          kind_d = q_op_i.regroup ? KindRegrp : KindGroup;
          grp_d  = tg;
          if (q_op_i.regroup) sgrp_d = tg;
          src_d  = src;
          tgt_d  = '0;
          if (tg != '0) ltg_d = tg;
          if (src != '0) lsrc_d = src;
        end
        CmdUnit: begin
          handled = 1'b1;
          svc_d  = info_byte(q_op_i.info, 0);
          kind_d = KindUnit;
          tgt_d  = q_op_i.info[47:24];
          src_d  = src;
          grp_d  = '0;
          if (src != '0) lsrc_d = src;
        end
        CmdHeader: begin
          handled = 1'b1;
          len = (hdr_len == 8'd0 || hdr_len > 8'(AliasMaxChars)) ?
                5'(AliasMaxChars) : hdr_len[4:0];
          exp_d = len; seen_d = 4'b0001; fill_d = '0; done_d = 1'b0;
          start_d = q_op_i.now;
          store_d[0] = '0;
        end
        CmdBlock: begin
          handled = 1'b1;
          bit_m  = 4'(1) << q_op_i.blk;
          offset = 5'(q_op_i.blk - 2'd1) * 5'(BlockChars);
          // Header state after a possible timeout reset this same beat.
          if (exp_d != '0 && (seen_d & bit_m) == '0 && offset < exp_d) begin
            take = (exp_d - offset > 5'(BlockChars)) ? 5'(BlockChars) : exp_d - offset;
            for (int i = 0; i < BlockChars; i++) begin
              c = info_byte(q_op_i.info, i);
              if (!stop && 5'(i) < take && 5'(offset + 5'(i)) < 5'(AliasMaxChars) &&
                  c >= 8'h20 && c <= 8'h7E) begin
                store_d[offset + 5'(i)] = c;
                written = written + 5'd1;
              end else begin
                stop = 1'b1;
              end
            end
            if (offset + written < 5'(StoreDepth)) store_d[offset + written] = '0;
            seen_d = seen_d | bit_m;
            if (offset + written > fill_d) fill_d = offset + written;
            if (fill_d >= exp_d) done_d = 1'b1;
          end
        end
        default: handled = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= 32'd1000000;
      kind_q <= '0; svc_q <= '0; grp_q <= '0; sgrp_q <= '0; src_q <= '0;
      tgt_q <= '0; ltg_q <= '0; lsrc_q <= '0; exp_q <= '0; seen_q <= '0;
      fill_q <= '0; done_q <= 1'b0; start_q <= '0;
      for (int i = 0; i < StoreDepth; i++) store_q[i] <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) tmo_q <= cfg_wdata_i;
      if (q_ready_o) out_vld_q <= q_valid_i;
      if (fire) begin
        kind_q <= kind_d; svc_q <= svc_d; grp_q <= grp_d; sgrp_q <= sgrp_d;
        src_q <= src_d; tgt_q <= tgt_d; ltg_q <= ltg_d; lsrc_q <= lsrc_d;
        exp_q <= exp_d; seen_q <= seen_d; fill_q <= fill_d; done_q <= done_d;
        start_q <= start_d;
        for (int i = 0; i < StoreDepth; i++) store_q[i] <= store_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= OutTW'({
        store_d[14], store_d[15], store_d[16], store_d[17], store_d[18],
        store_d[19], store_d[20],
        store_d[7], store_d[8], store_d[9], store_d[10], store_d[11],
        store_d[12], store_d[13],
        store_d[0], store_d[1], store_d[2], store_d[3], store_d[4],
        store_d[5], store_d[6],
        fill_d, done_d, sgrp_d, tgt_d, src_d, grp_d, svc_d, kind_d, handled});
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_q;
endmodule

// ----- rtl/core/link_control_word_parser.sv -----
// Link control word parser: classifies words and keeps call record and talker alias.
// Each input beat gives exactly one output beat. The block takes one beat per cycle while
// neither side stalls. A result is registered first in the front classifier's one-entry
// queue, then in the executor that updates the call record and the 22-byte alias store
// and registers the whole result. Either side may stall without losing beats.
// A clear request is marked by tuser; its data bits are ignored.
`timescale 1ns / 1ps
`include "link_control_word_parser_assert.svh"
module link_control_word_parser import lcwp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,    // alias_timeout_us
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // lco, mfid, info_bytes, fec_ok, now_us (low bit up)
  input  logic [InTW-1:0]  s_axis_tdata,
  // req_type
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // handled, call_kind, service_options, talkgroup, source, target,
  // patch_supergroup, alias_ready, alias_length, alias_chars_a/b/c (low bit up)
  output logic [OutTW-1:0] m_axis_tdata
);
  logic q_valid, q_ready;
  op_t  q_op;

  lcwp_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_op_o(q_op)
  );

  lcwp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_op_i(q_op),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_o(m_axis_tdata)
  );

  `LCWP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `LCWP_ASSERT(a_ready_gt, clk_i, rst_ni, (!m_axis_tvalid || m_axis_tready) |-> q_ready)
  `LCWP_ASSERT_NEXT(a_q_to_out, clk_i, rst_ni, q_valid && q_ready, m_axis_tvalid)
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the link control word parser.
`timescale 1ns / 1ps
module tb;
  import lcwp_pkg::*;

  typedef struct {
    bit        req_type;
    bit [7:0]  lco;
    bit [7:0]  mfid;
    bit [55:0] info;
    bit        fec_ok;
    bit [61:0] now;
  } word_t;

  typedef struct {
    bit        handled;
    bit [1:0]  kind;
    bit [7:0]  svc;
    bit [15:0] tg;
    bit [23:0] src;
    bit [23:0] tgt;
    bit [15:0] sgrp;
    bit        ready;
    bit [4:0]  len;
    bit [55:0] ca, cb, cc;
  } record_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [31:0] cfg_wdata_i = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic s_axis_tuser = 0;
  logic s_axis_tready, m_axis_tvalid;
  logic [InTW-1:0] s_axis_tdata = '0;
  logic [OutTW-1:0] m_axis_tdata;

  link_control_word_parser dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Predictor state.
  bit [31:0] m_timeout;
  bit [1:0]  m_kind;
  bit [7:0]  m_svc;
  bit [15:0] m_grp, m_sgrp, m_last_tg;
  bit [23:0] m_src, m_tgt, m_last_src;
  bit [4:0]  m_exp, m_fill;
  bit [3:0]  m_seen;
  bit        m_done;
  bit [61:0] m_start;
  bit [7:0]  m_store[StoreDepth];

  word_t   pending_words[$];
  record_t expected_records[$];
  int      errors = 0;
  int      hold_off = 0;
  longint  cycles = 0;

  function automatic bit [7:0] ib(bit [55:0] info, int k);
    return info[8 * (6 - k) +: 8];
  endfunction

  function automatic void clear_alias();
    m_exp = 0; m_seen = 0; m_fill = 0; m_done = 0; m_start = 0;
    m_store[0] = 0;
  endfunction

  function automatic void copy_block(int blk, bit [55:0] info);
    int offset, take, written;
    bit [7:0] c;
    offset = (blk - 1) * BlockChars;
    written = 0;
    if (m_exp == 0 || m_seen[blk] || offset >= m_exp) return;
    take = m_exp - offset;
    if (take > BlockChars) take = BlockChars;
    for (int i = 0; i < take; i++) begin
      c = ib(info, i);
      if (offset + written >= AliasMaxChars || c < 8'h20 || c > 8'h7E) break;
      m_store[offset + written] = c;
      written++;
    end
    if (offset + written < StoreDepth) m_store[offset + written] = 0;
    m_seen[blk] = 1;
    if (offset + written > m_fill) m_fill = 5'(offset + written);
    if (m_fill >= m_exp) m_done = 1;
  endfunction

  function automatic bit decode_word(word_t w);
    bit [5:0]  op;
    bit [15:0] tg;
    bit [23:0] src;
    bit [7:0]  len;
    op = w.lco[5:0];
    tg = {ib(w.info, 2), ib(w.info, 3)};
    src = {ib(w.info, 4), ib(w.info, 5), ib(w.info, 6)};
    if (m_exp != 0 && !m_done && w.now >= m_start && (w.now - m_start) > m_timeout)
      clear_alias();
    if (w.mfid > 8'd1) return 0;
    if (op == OpGroupVoice || op == OpRegroup) begin
      if ((m_last_tg != 0 && tg != 0 && m_last_tg != tg) ||
          (m_last_src != 0 && src != 0 && m_last_src != src))
        clear_alias();
    end
    case (op)
      OpGroupVoice, OpRegroup: begin
        m_svc = ib(w.info, 0);
        m_kind = (op == OpGroupVoice) ? KindGroup : KindRegrp;
        m_grp = tg;
        if (op == OpRegroup) m_sgrp = tg;
        m_src = src;
        m_tgt = 0;
        if (tg != 0) m_last_tg = tg;
        if (src != 0) m_last_src = src;
        return 1;
      end
      OpUnitToUnit: begin
        m_svc = ib(w.info, 0);
        m_kind = KindUnit;
        m_tgt = {ib(w.info, 1), ib(w.info, 2), ib(w.info, 3)};
        m_src = src;
        m_grp = 0;
        if (src != 0) m_last_src = src;
        return 1;
      end
      OpAliasHdr: begin
        len = ib(w.info, 1);
        clear_alias();
        if (len == 0 || len > AliasMaxChars) len = 8'(AliasMaxChars);
        m_exp = len[4:0];
        m_seen = 4'h1;
        m_start = w.now;
        return 1;
      end
      OpAliasBlk1, OpAliasBlk2, OpAliasBlk3: begin
        copy_block(op - OpAliasHdr, w.info);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic record_t predict_record(word_t w);
    record_t r;
    r.handled = 0;
    if (w.req_type) begin
      m_kind = 0; m_svc = 0; m_grp = 0; m_src = 0; m_tgt = 0; m_sgrp = 0;
      clear_alias();
    end else if (w.fec_ok) begin
      r.handled = decode_word(w);
    end
    r.kind = m_kind; r.svc = m_svc; r.tg = m_grp; r.src = m_src; r.tgt = m_tgt;
    r.sgrp = m_sgrp; r.ready = m_done; r.len = m_fill;
    for (int i = 0; i < BlockChars; i++) begin
      r.ca = {r.ca[47:0], m_store[i]};
      r.cb = {r.cb[47:0], m_store[i + 7]};
      r.cc = {r.cc[47:0], m_store[i + 14]};
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(99) < 50) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3);
    return $urandom_range(30);
  endfunction

  // Driver.
  int send_gap = 0;
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        w = pending_words.pop_front();
        expected_records.push_back(predict_record(w));
        send_gap = gap_len();
      end else if (!s_axis_tvalid && send_gap > 0) begin
        send_gap--;
      end
      if ((!s_axis_tvalid || s_axis_tready) && send_gap == 0 && pending_words.size() > 0)
      begin
        w = pending_words[0];
        s_axis_tvalid <= 1;
        s_axis_tuser <= w.req_type;
        s_axis_tdata <= InTW'({w.now, w.fec_ok, w.info, w.mfid, w.lco});
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // Monitor.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    record_t e, a;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        {a.cc, a.cb, a.ca, a.len, a.ready, a.sgrp, a.tgt, a.src, a.tg, a.svc, a.kind,
         a.handled} = m_axis_tdata[OutW-1:0];
        if (expected_records.size() == 0) begin
          $error("result beat with no expectation waiting");
          errors++;
        end else begin
          e = expected_records.pop_front();
          if (a.handled !== e.handled) begin
            $error("handled exp %0h got %0h", e.handled, a.handled); errors++; end
          if (a.kind !== e.kind) begin
            $error("call_kind exp %0h got %0h", e.kind, a.kind); errors++; end
          if (a.svc !== e.svc) begin
            $error("service_options exp %0h got %0h", e.svc, a.svc); errors++; end
          if (a.tg !== e.tg) begin
            $error("talkgroup exp %0h got %0h", e.tg, a.tg); errors++; end
          if (a.src !== e.src) begin
            $error("source exp %0h got %0h", e.src, a.src); errors++; end
          if (a.tgt !== e.tgt) begin
            $error("target exp %0h got %0h", e.tgt, a.tgt); errors++; end
          if (a.sgrp !== e.sgrp) begin
            $error("patch_supergroup exp %0h got %0h", e.sgrp, a.sgrp); errors++; end
          if (a.ready !== e.ready) begin
            $error("alias_ready exp %0h got %0h", e.ready, a.ready); errors++; end
          if (a.len !== e.len) begin
            $error("alias_length exp %0h got %0h", e.len, a.len); errors++; end
          if (a.ca !== e.ca) begin
            $error("alias_chars_a exp %0h got %0h", e.ca, a.ca); errors++; end
          if (a.cb !== e.cb) begin
            $error("alias_chars_b exp %0h got %0h", e.cb, a.cb); errors++; end
          if (a.cc !== e.cc) begin
            $error("alias_chars_c exp %0h got %0h", e.cc, a.cc); errors++; end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        if (m_axis_tvalid && m_axis_tready) recv_gap = gap_len();
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("FAIL link_control_word_parser");
      $finish;
    end
  end

  function automatic bit [55:0] printable_info(int n);
    bit [55:0] v;
    for (int i = 0; i < 7; i++)
      v = {v[47:0], (i == n) ? 8'h01 : 8'($urandom_range(8'h20, 8'h7E))};
    return v;
  endfunction

  // Small ids give frequent repeats so that alias sequences survive talker checks.
  function automatic word_t random_word(ref bit [61:0] clock_us);
    word_t w;
    int sel;
    w.req_type = ($urandom_range(99) < 3);
    w.lco = {$urandom_range(3) == 0 ? 2'($urandom) : 2'b00, 6'd0};
    w.mfid = ($urandom_range(99) < 90) ? 8'($urandom_range(1)) : 8'($urandom);
    w.fec_ok = ($urandom_range(99) < 92);
    w.info = 56'({$urandom, $urandom});
    clock_us += $urandom_range(99) < 90 ? $urandom_range(400000) : 64'($urandom);
    w.now = ($urandom_range(99) < 3) ? 62'({$urandom, $urandom}) : clock_us;
    sel = $urandom_range(99);
    if (sel < 20) begin
      w.lco[5:0] = OpGroupVoice;
      w.info[39:0] = {16'($urandom_range(3)), 24'($urandom_range(2))};
    end else if (sel < 28) begin
      w.lco[5:0] = OpRegroup;
      w.info[39:0] = {16'($urandom_range(3)), 24'($urandom_range(2))};
    end else if (sel < 35) begin
      w.lco[5:0] = OpUnitToUnit;
      w.info[23:0] = 24'($urandom_range(2));
    end else if (sel < 50) begin
      w.lco[5:0] = OpAliasHdr;
      w.info[47:40] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(21));
    end else if (sel < 90) begin
      w.lco[5:0] = 6'($urandom_range(OpAliasBlk1, OpAliasBlk3));
      w.info = printable_info($urandom_range(4) == 0 ? $urandom_range(6) : 7);
    end else begin
      w.lco[5:0] = 6'($urandom);
    end
    return w;
  endfunction

  task automatic push_word(bit rq, bit [7:0] lco, bit [7:0] mfid, bit [55:0] info,
                           bit fec, bit [61:0] now);
    word_t w;
    w.req_type = rq; w.lco = lco; w.mfid = mfid; w.info = info;
    w.fec_ok = fec; w.now = now;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_records.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(bit [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
    m_timeout = value;
  endtask

  initial begin
    bit [61:0] clock_us;
    bit [31:0] timeouts[4] = '{32'd0, 32'd1000000, 32'd250000, 32'hFFFFFFFF};
    m_timeout = 1000000;
    foreach (m_store[i]) m_store[i] = 0;
    m_kind = 0; m_svc = 0; m_grp = 0; m_sgrp = 0; m_last_tg = 0; m_src = 0;
    m_tgt = 0; m_last_src = 0;
    clear_alias();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: alias assembly, calls, special cases.
    push_word(0, OpAliasBlk1, 0, "ABCDEFG", 1, 10);
    push_word(0, OpAliasHdr, 0, 56'h00_0A_00_00_00_00_00, 1, 100);
    push_word(0, OpAliasBlk1, 1, "Hello W", 1, 200);
    push_word(0, OpAliasBlk1, 1, "zzzzzzz", 1, 210);
    push_word(0, OpAliasBlk2, 0, {"or", 8'h1F, "ld!!"}, 1, 220);
    push_word(0, OpAliasBlk3, 0, "~~~~~~~", 1, 230);
    push_word(0, OpAliasHdr, 0, 56'hFF_00_00_00_00_00_00, 1, 300);
    push_word(0, OpAliasBlk3, 0, " ~ ~ ~ ", 1, 310);
    push_word(0, OpAliasBlk1, 0, "1234567", 1, 320);
    push_word(0, OpAliasBlk2, 0, "89ABCDE", 1, 330);
    push_word(0, 8'hC0 | OpGroupVoice, 0, 56'hC7_00_12_34_AB_CD_EF, 1, 400);
    push_word(0, OpRegroup, 1, 56'h47_FF_FF_FF_FF_FF_FF, 1, 500);
    push_word(0, OpUnitToUnit, 0, 56'h00_11_22_33_00_00_00, 1, 600);
    push_word(0, OpAliasHdr, 0, 56'h00_16_00_00_00_00_00, 1, 700);
    push_word(0, OpGroupVoice, 8'hFF, 56'hFF_FF_FF_FF_FF_FF_FF, 1, 2000000);
    push_word(0, OpAliasBlk1, 0, "late...", 1, 62'h3FFFFFFFFFFFFFFF);
    push_word(0, OpGroupVoice, 0, 56'hFF_FF_FF_FF_FF_FF_FF, 0, 62'h3FFFFFFFFFFFFFFF);
    push_word(0, 8'h3F, 0, 56'h0, 1, 0);
    push_word(1, 8'hFF, 8'hFF, 56'hFF_FF_FF_FF_FF_FF_FF, 0, 62'h3FFFFFFFFFFFFFFF);
    push_word(0, OpAliasHdr, 0, 56'h00_07_00_00_00_00_00, 1, 50);
    push_word(0, OpAliasBlk1, 0, "ShortID", 1, 40);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_timeout(timeouts[phase]);
      if (phase == 1) hold_off = 300;
      clock_us = 0;
      for (int i = 0; i < 185; i++) pending_words.push_back(random_word(clock_us));
      drain();
    end

    if (errors == 0 && expected_records.size() == 0) begin
      $display("PASS link_control_word_parser");
    end else begin
      $display("FAIL link_control_word_parser");
    end
    $finish;
  end
endmodule
